>>> rtl/pfb_pkg.sv
// shared types, constants and helpers of the paged framebuffer refresh block
package pfb_pkg;

    // default geometry of the panel
    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    // one memory row holds eight column bytes
    localparam int LANES    = 8;
    localparam int ROW_W    = LANES * 8;
    // at most this many words of a page go to the panel
    localparam int MAX_SEND = 16;

    // command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_PIXEL   = 2'd0,
        CMD_FILL    = 2'd1,
        CMD_REFRESH = 2'd2
    } pfb_cmd_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_WR,
        ST_NORM,
        ST_FILL,
        ST_CMP,
        ST_CMP_LAST,
        ST_SEND,
        ST_SEND_LAST
    } pfb_state_t;

    // input transaction
    typedef struct packed {
        logic [1:0] command;
        logic [6:0] x_pos;
        logic [5:0] y_pos;
        logic [6:0] x_last;
        logic [5:0] y_last;
        logic       pixel_value;
    } pfb_in_t;

    // result transaction
    typedef struct packed {
        logic [2:0]  page_number;
        logic [3:0]  word_number;
        logic [63:0] page_data;
        logic        last_word;
    } pfb_out_t;

    // index width for n entries, never below one bit
    function automatic int width_of(int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> rtl/paged_lcd_framebuffer_refresh.sv
// top level of the paged monochrome framebuffer with dirty page refresh
//
//   channel   handshake                  payload
//   ------    -------------------------  --------------------------------------
//   request   start & !busy              command, x_pos, y_pos, x_last, y_last,
//                                        pixel_value
//   result    result_strobe, one cycle   page_number, word_number, page_data,
//                                        last_word
//
// both buffers are row memories of eight column bytes per row, with a write
// and a read port each; after reset a clearing pass zeroes
// PAGES*ceil(COLUMNS/8) rows with busy high
// put pixel: read of the row, then write back
// fill: locate the start, then one write per eight-column group touched
// refresh tick: compare and copy a page, then send min(ceil(COLUMNS/8),16)
// words of a dirty page, one word a cycle
// results cannot be stalled: each word is on the port for exactly one cycle
module paged_lcd_framebuffer_refresh #(
    parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfb_pkg::PAGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pfb_pkg::pfb_in_t  request,
    output logic              result_strobe,
    output pfb_pkg::pfb_out_t result
);
    import pfb_pkg::*;

    localparam int WORDS = (COLUMNS + 7) / 8;
    localparam int ROWS  = PAGES * WORDS;
    localparam int RA_W  = width_of(ROWS);

    logic             front_we;
    logic [LANES-1:0] front_be;
    logic [RA_W-1:0]  front_waddr;
    logic [ROW_W-1:0] front_wdata;
    logic [RA_W-1:0]  front_raddr;
    logic [ROW_W-1:0] front_rdata;
    logic             shadow_we;
    logic [RA_W-1:0]  shadow_waddr;
    logic [ROW_W-1:0] shadow_wdata;
    logic [RA_W-1:0]  shadow_raddr;
    logic [ROW_W-1:0] shadow_rdata;

    // sequencer
    pfb_ctrl #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES),
        .RA_W    (RA_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result_strobe (result_strobe),
        .result        (result),
        .front_we      (front_we),
        .front_be      (front_be),
        .front_waddr   (front_waddr),
        .front_wdata   (front_wdata),
        .front_raddr   (front_raddr),
        .front_rdata   (front_rdata),
        .shadow_we     (shadow_we),
        .shadow_waddr  (shadow_waddr),
        .shadow_wdata  (shadow_wdata),
        .shadow_raddr  (shadow_raddr),
        .shadow_rdata  (shadow_rdata)
    );

    // front buffer
    pfb_ram #(
        .DEPTH (ROWS),
        .AW    (RA_W)
    ) u_front (
        .clk   (clk),
        .we    (front_we),
        .be    (front_be),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .raddr (front_raddr),
        .rdata (front_rdata)
    );

    // shadow buffer, always written as whole rows
    pfb_ram #(
        .DEPTH (ROWS),
        .AW    (RA_W)
    ) u_shadow (
        .clk   (clk),
        .we    (shadow_we),
        .be    ({LANES{1'b1}}),
        .waddr (shadow_waddr),
        .wdata (shadow_wdata),
        .raddr (shadow_raddr),
        .rdata (shadow_rdata)
    );

endmodule

>>> rtl/pfb_ram.sv
// row memory with byte lane write enables and registered read
module pfb_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [pfb_pkg::LANES-1:0] be,
    input  logic [AW-1:0]             waddr,
    input  logic [pfb_pkg::ROW_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [pfb_pkg::ROW_W-1:0] rdata
);
    import pfb_pkg::*;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rdata_reg;

    // byte lane write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                if (be[k])
                begin
                    mem[waddr][k*8 +: 8] <= wdata[k*8 +: 8];
                end
            end
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pfb_ctrl.sv
// sequencer: clearing pass, pixel read-modify-write, fill walk, page compare and send
module pfb_ctrl #(
    parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfb_pkg::PAGES_DEF,
    parameter int RA_W    = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  pfb_pkg::pfb_in_t          request,
    output logic                      result_strobe,
    output pfb_pkg::pfb_out_t         result,
    // front buffer port
    output logic                      front_we,
    output logic [pfb_pkg::LANES-1:0] front_be,
    output logic [RA_W-1:0]           front_waddr,
    output logic [pfb_pkg::ROW_W-1:0] front_wdata,
    output logic [RA_W-1:0]           front_raddr,
    input  logic [pfb_pkg::ROW_W-1:0] front_rdata,
    // shadow buffer port
    output logic                      shadow_we,
    output logic [RA_W-1:0]           shadow_waddr,
    output logic [pfb_pkg::ROW_W-1:0] shadow_wdata,
    output logic [RA_W-1:0]           shadow_raddr,
    input  logic [pfb_pkg::ROW_W-1:0] shadow_rdata
);
    import pfb_pkg::*;

    localparam int WORDS = (COLUMNS + 7) / 8;
    localparam int ROWS  = PAGES * WORDS;
    localparam int TOTAL = PAGES * COLUMNS;
    localparam int NSEND = (WORDS > MAX_SEND) ? MAX_SEND : WORDS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int PG_W  = width_of(PAGES);
    localparam int WD_W  = width_of(WORDS);
    localparam int LIN_W = $clog2(16 * COLUMNS + 128);

    // control registers
    pfb_state_t      state_reg, state_next;
    logic [RA_W-1:0] row_reg, row_next;
    logic [PG_W-1:0] rpage_reg, rpage_next;
    logic [WD_W-1:0] wd_reg, wd_next;
    logic [WD_W-1:0] pend_wd_reg, pend_wd_next;
    logic            pend_reg, pend_next;
    logic            dirty_reg, dirty_next;

    // payload registers
    logic [RA_W-1:0]  prow_reg, prow_next;
    logic [5:0]       pbit_reg, pbit_next;
    logic             pval_reg, pval_next;
    logic [LIN_W-1:0] b_reg, b_next;
    logic [LIN_W-1:0] e_reg, e_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [PG_W-1:0]  fpage_reg, fpage_next;
    logic [6:0]       nx_reg, nx_next;
    logic [7:0]       fbyte_reg, fbyte_next;

    logic             accept;
    pfb_cmd_t         cmd;

    // decode of an arriving transaction
    logic [2:0]       in_page;
    logic             pix_ok;
    logic [RA_W-1:0]  pix_row;
    logic [LIN_W-1:0] fill_s;
    logic [LIN_W-1:0] fill_e;
    logic             fill_ok;

    // one step of the fill walk
    logic [CW-1:0]    f_gend;
    logic [CW-1:0]    f_avail;
    logic [LIN_W-1:0] f_rem;
    logic [2:0]       f_take;
    logic             f_done;
    logic             f_wrap;
    logic [LANES-1:0] f_be;
    logic [RA_W-1:0]  f_row;

    // refresh addressing
    logic [RA_W-1:0]  ref_row;
    logic [RA_W-1:0]  pend_row;
    logic             row_diff;
    logic             norm_over;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign cmd    = pfb_cmd_t'(request.command);

    // transaction decode
    always_comb
    begin
        in_page = request.y_pos[5:3];
        pix_ok  = (int'(request.x_pos) < COLUMNS) && (int'(in_page) < PAGES);
        pix_row = RA_W'(int'(in_page) * WORDS + int'(request.x_pos[6:3]));
        fill_s  = LIN_W'(int'(request.x_pos) + int'(in_page) * COLUMNS);
        fill_e  = LIN_W'(int'(request.x_last) + int'(request.y_last[5:3]) * COLUMNS);
        fill_ok = (fill_e >= fill_s) && (int'(fill_s) < TOTAL);
    end

    // fill walk step: bytes of the current column group up to the end address
    always_comb
    begin
        f_gend = ((col_reg | CW'(7)) > CW'(COLUMNS - 1)) ? CW'(COLUMNS - 1)
                                                         : (col_reg | CW'(7));
        f_avail = f_gend - col_reg;
        f_rem   = e_reg - b_reg;
        f_take  = (f_rem < LIN_W'(f_avail)) ? f_rem[2:0] : f_avail[2:0];
        f_done  = (f_rem == LIN_W'(f_take));
        f_wrap  = (f_gend == CW'(COLUMNS - 1)) && (f_take == f_avail[2:0]);
        for (int k = 0; k < LANES; k++)
        begin
            f_be[k] = (3'(k) >= col_reg[2:0]) && (3'(k) <= col_reg[2:0] + f_take);
        end
        f_row = RA_W'(int'(fpage_reg) * WORDS + int'(col_reg >> 3));
    end

    // refresh addressing and compare
    always_comb
    begin
        ref_row   = RA_W'(int'(rpage_reg) * WORDS + int'(wd_reg));
        pend_row  = RA_W'(int'(rpage_reg) * WORDS + int'(pend_wd_reg));
        row_diff  = (front_rdata != shadow_rdata);
        norm_over = (int'(nx_reg) >= COLUMNS);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (row_reg == RA_W'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_PIXEL:   state_next = pix_ok ? ST_PIX_WR : ST_IDLE;
                        CMD_FILL:    state_next = fill_ok ? ST_NORM : ST_IDLE;
                        CMD_REFRESH: state_next = ST_CMP;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_NORM:
            begin
                if (!norm_over)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (f_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CMP:
            begin
                if (wd_reg == WD_W'(WORDS - 1))
                begin
                    state_next = ST_CMP_LAST;
                end
            end
            ST_CMP_LAST:
            begin
                state_next = (dirty_reg || row_diff) ? ST_SEND : ST_IDLE;
            end
            ST_SEND:
            begin
                if (wd_reg == WD_W'(NSEND - 1))
                begin
                    state_next = ST_SEND_LAST;
                end
            end
            ST_SEND_LAST:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // register next values
    always_comb
    begin
        row_next     = row_reg;
        rpage_next   = rpage_reg;
        wd_next      = wd_reg;
        pend_wd_next = pend_wd_reg;
        pend_next    = 1'b0;
        dirty_next   = dirty_reg;
        prow_next    = prow_reg;
        pbit_next    = pbit_reg;
        pval_next    = pval_reg;
        b_next       = b_reg;
        e_next       = e_reg;
        col_next     = col_reg;
        fpage_next   = fpage_reg;
        nx_next      = nx_reg;
        fbyte_next   = fbyte_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                row_next = (row_reg == RA_W'(ROWS - 1)) ? '0 : row_reg + 1'b1;
            end
            ST_IDLE:
            begin
                prow_next  = pix_row;
                pbit_next  = {request.x_pos[2:0], request.y_pos[2:0]};
                pval_next  = request.pixel_value;
                b_next     = fill_s;
                e_next     = (int'(fill_e) >= TOTAL) ? LIN_W'(TOTAL - 1) : fill_e;
                nx_next    = request.x_pos;
                fpage_next = PG_W'(in_page);
                fbyte_next = request.pixel_value ? 8'h00 : 8'hff;
                wd_next    = '0;
                dirty_next = 1'b0;
            end
            ST_PIX_WR:
            begin
            end
            ST_NORM:
            begin
                if (norm_over)
                begin
                    nx_next    = nx_reg - 7'(COLUMNS);
                    fpage_next = fpage_reg + 1'b1;
                end
                else
                begin
                    col_next = CW'(nx_reg);
                end
            end
            ST_FILL:
            begin
                b_next = b_reg + LIN_W'(f_take) + 1'b1;
                if (f_wrap)
                begin
                    col_next   = '0;
                    fpage_next = fpage_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + CW'(f_take) + CW'(1);
                end
            end
            ST_CMP:
            begin
                pend_next    = 1'b1;
                pend_wd_next = wd_reg;
                wd_next      = (wd_reg == WD_W'(WORDS - 1)) ? '0 : wd_reg + 1'b1;
                if (pend_reg && row_diff)
                begin
                    dirty_next = 1'b1;
                end
            end
            ST_CMP_LAST:
            begin
                wd_next = '0;
                if (!(dirty_reg || row_diff))
                begin
                    rpage_next = (rpage_reg == PG_W'(PAGES - 1)) ? '0 : rpage_reg + 1'b1;
                end
            end
            ST_SEND:
            begin
                pend_next    = 1'b1;
                pend_wd_next = wd_reg;
                wd_next      = (wd_reg == WD_W'(NSEND - 1)) ? '0 : wd_reg + 1'b1;
            end
            ST_SEND_LAST:
            begin
                rpage_next = (rpage_reg == PG_W'(PAGES - 1)) ? '0 : rpage_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // memory controls and result port
    always_comb
    begin
        front_we     = 1'b0;
        front_be     = '0;
        front_waddr  = row_reg;
        front_wdata  = '0;
        front_raddr  = pix_row;
        shadow_we    = 1'b0;
        shadow_waddr = row_reg;
        shadow_wdata = '0;
        shadow_raddr = ref_row;
        result_strobe      = 1'b0;
        result.page_number = 3'(rpage_reg);
        result.word_number = 4'(pend_wd_reg);
        result.page_data   = front_rdata;
        result.last_word   = (pend_wd_reg == WD_W'(NSEND - 1));
        unique case (state_reg)
            ST_CLEAR:
            begin
                front_we  = 1'b1;
                front_be  = '1;
                shadow_we = 1'b1;
            end
            ST_IDLE:
            begin
            end
            ST_PIX_WR:
            begin
                front_we              = 1'b1;
                front_be              = LANES'(1) << pbit_reg[5:3];
                front_waddr           = prow_reg;
                front_wdata           = front_rdata;
                front_wdata[pbit_reg] = pval_reg;
            end
            ST_NORM:
            begin
            end
            ST_FILL:
            begin
                front_we    = 1'b1;
                front_be    = f_be;
                front_waddr = f_row;
                front_wdata = {LANES{fbyte_reg}};
            end
            ST_CMP:
            begin
                front_raddr  = ref_row;
                shadow_we    = pend_reg;
                shadow_waddr = pend_row;
                shadow_wdata = front_rdata;
            end
            ST_CMP_LAST:
            begin
                shadow_we    = 1'b1;
                shadow_waddr = pend_row;
                shadow_wdata = front_rdata;
            end
            ST_SEND:
            begin
                front_raddr   = ref_row;
                result_strobe = pend_reg;
            end
            ST_SEND_LAST:
            begin
                result_strobe = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            row_reg     <= '0;
            rpage_reg   <= '0;
            wd_reg      <= '0;
            pend_wd_reg <= '0;
            pend_reg    <= 1'b0;
            dirty_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            rpage_reg   <= rpage_next;
            wd_reg      <= wd_next;
            pend_wd_reg <= pend_wd_next;
            pend_reg    <= pend_next;
            dirty_reg   <= dirty_next;
        end
    end

    // transaction payload
    always_ff @(posedge clk)
    begin
        prow_reg  <= prow_next;
        pbit_reg  <= pbit_next;
        pval_reg  <= pval_next;
        b_reg     <= b_next;
        e_reg     <= e_next;
        col_reg   <= col_next;
        fpage_reg <= fpage_next;
        nx_reg    <= nx_next;
        fbyte_reg <= fbyte_next;
    end

    // results come only out of a page send
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (state_reg == ST_SEND || state_reg == ST_SEND_LAST))
        else $error("result strobe outside page send");

    // shadow is written only by the clearing pass or the page compare
    assert property (@(posedge clk) disable iff (!rst_n)
        shadow_we |-> (state_reg == ST_CLEAR || state_reg == ST_CMP ||
                       state_reg == ST_CMP_LAST))
        else $error("shadow written outside compare");

    // every front write touches at least one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        front_we |-> (front_be != '0))
        else $error("front write with no byte enabled");

    // a refresh tick always occupies the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_REFRESH) |=> (state_reg == ST_CMP))
        else $error("refresh tick not started");

    // refresh page stays inside the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(rpage_reg) < PAGES)
        else $error("refresh page out of range");

endmodule

>>> dv/tb_paged_lcd_framebuffer_refresh.sv
// self-checking testbench of the paged framebuffer with dirty page refresh
module tb_paged_lcd_framebuffer_refresh;
    timeunit 1ns;
    timeprecision 1ps;

    import pfb_pkg::*;

    localparam int unsigned PANEL_COLS  = 128;
    localparam int unsigned PANEL_PAGES = 8;
    localparam int unsigned PANEL_BYTES = PANEL_COLS * PANEL_PAGES;
    localparam int unsigned PAGE_WORDS  = 16;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_WAIT  = 80;
    localparam int unsigned REPORT_MAX  = 10;
    // command code the block does not decode
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // one request waiting for the driver, with the idle rate of its phase
    typedef struct {
        pfb_in_t     req;
        int unsigned gap_pct;
    } queued_cmd_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    pfb_in_t  request = '0;
    logic     result_strobe;
    pfb_out_t result;

    queued_cmd_t cmd_backlog[$];
    pfb_out_t    page_words_due[$];

    // predicted contents of the front buffer, the shadow and the scan position
    logic [7:0]  panel_bytes[PANEL_BYTES];
    logic [7:0]  sent_bytes[PANEL_BYTES];
    logic [2:0]  scan_page;

    logic        req_taken = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    paged_lcd_framebuffer_refresh dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result_strobe (result_strobe),
        .result        (result)
    );

    // clock
    always #5ns clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic queued_cmd_t make_item(logic [1:0] cmd, int unsigned x, int unsigned y,
                                              int unsigned xl, int unsigned yl, logic v,
                                              int unsigned gap);
        queued_cmd_t item;
        item.req.command     = cmd;
        item.req.x_pos       = x[6:0];
        item.req.y_pos       = y[5:0];
        item.req.x_last      = xl[6:0];
        item.req.y_last      = yl[5:0];
        item.req.pixel_value = v;
        item.gap_pct         = gap;
        return item;
    endfunction

    task automatic log_mismatch(string what, pfb_out_t want, pfb_out_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%t %s: expected page %0d word %0d data %h last %b, got page %0d word %0d data %h last %b",
                     $realtime, what, want.page_number, want.word_number, want.page_data,
                     want.last_word, got.page_number, got.word_number, got.page_data,
                     got.last_word);
    endtask

    // driver: new request at the falling edge once the previous one was taken
    always @(negedge clk)
    begin : driver
        queued_cmd_t item;
        if (rst_n && !(start && !req_taken))
        begin
            if (cmd_backlog.size() != 0 &&
                $urandom_range(99) >= cmd_backlog[0].gap_pct)
            begin
                item = cmd_backlog.pop_front();
                request <= item.req;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check results, then predict the effect of a taken request
    always @(posedge clk)
    begin : monitor
        pfb_out_t    want;
        pfb_out_t    sent;
        int unsigned lo_addr;
        int unsigned hi_addr;
        int unsigned base;
        bit          dirty;
        logic [63:0] word;
        if (rst_n)
        begin
            // result side
            if (result_strobe)
            begin
                if (page_words_due.size() == 0)
                    log_mismatch("result with nothing expected", '0, result);
                else
                begin
                    want = page_words_due.pop_front();
                    if (result.page_number !== want.page_number ||
                        result.word_number !== want.word_number ||
                        result.page_data !== want.page_data ||
                        result.last_word !== want.last_word)
                        log_mismatch("result mismatch", want, result);
                end
            end
            // request side
            req_taken <= start && !busy;
            if (start && !busy)
            begin
                case (request.command)
                    CMD_PIXEL:
                    begin
                        lo_addr = request.x_pos + (request.y_pos >> 3) * PANEL_COLS;
                        panel_bytes[lo_addr][request.y_pos[2:0]] = request.pixel_value;
                    end
                    CMD_FILL:
                    begin
                        lo_addr = request.x_pos + (request.y_pos >> 3) * PANEL_COLS;
                        hi_addr = request.x_last + (request.y_last >> 3) * PANEL_COLS;
                        if (hi_addr >= lo_addr && lo_addr < PANEL_BYTES)
                        begin
                            if (hi_addr >= PANEL_BYTES)
                                hi_addr = PANEL_BYTES - 1;
                            for (int unsigned a = lo_addr; a <= hi_addr; a++)
                                panel_bytes[a] = request.pixel_value ? 8'h00 : 8'hff;
                        end
                    end
                    CMD_REFRESH:
                    begin
                        base = scan_page * PANEL_COLS;
                        dirty = 1'b0;
                        for (int unsigned c = 0; c < PANEL_COLS; c++)
                            if (panel_bytes[base + c] != sent_bytes[base + c])
                                dirty = 1'b1;
                        if (dirty)
                        begin
                            for (int unsigned c = 0; c < PANEL_COLS; c++)
                                sent_bytes[base + c] = panel_bytes[base + c];
                            for (int unsigned w = 0; w < PAGE_WORDS; w++)
                            begin
                                for (int unsigned b = 0; b < 8; b++)
                                    word[8*b +: 8] = sent_bytes[base + w*8 + b];
                                sent.page_number = scan_page;
                                sent.word_number = w[3:0];
                                sent.page_data   = word;
                                sent.last_word   = (w == PAGE_WORDS - 1);
                                page_words_due.push_back(sent);
                            end
                        end
                        scan_page = scan_page + 3'd1;
                    end
                    default:
                        ;
                endcase
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int unsigned gap_by_phase[4];
        int unsigned roll;
        int unsigned s_addr;
        int unsigned e_addr;
        gap_by_phase = '{0, 79, 0, 12};
        for (int unsigned a = 0; a < PANEL_BYTES; a++)
        begin
            panel_bytes[a] = 8'h00;
            sent_bytes[a]  = 8'h00;
        end
        scan_page = 3'd0;

        // directed: clean refresh, pixel corners, fills, unused command, then refresh ticks and more fills
        cmd_backlog.push_back(make_item(CMD_REFRESH, 0, 0, 0, 0, 1'b0, 0));
        cmd_backlog.push_back(make_item(CMD_PIXEL, 0, 0, 0, 0, 1'b1, 0));
        cmd_backlog.push_back(make_item(CMD_PIXEL, 127, 63, 127, 63, 1'b1, 0));
        cmd_backlog.push_back(make_item(CMD_PIXEL, 127, 63, 0, 0, 1'b0, 0));
        cmd_backlog.push_back(make_item(CMD_PIXEL, 64, 35, 12, 50, 1'b1, 0));
        cmd_backlog.push_back(make_item(CMD_FILL, 0, 0, 127, 63, 1'b0, 0));
        cmd_backlog.push_back(make_item(CMD_FILL, 100, 40, 5, 8, 1'b1, 0));
        cmd_backlog.push_back(make_item(CMD_FILL, 3, 9, 120, 9, 1'b1, 0));
        cmd_backlog.push_back(make_item(CMD_FILL, 120, 56, 127, 63, 1'b1, 0));
        cmd_backlog.push_back(make_item(CMD_UNUSED, 127, 63, 127, 63, 1'b1, 0));
        for (int unsigned i = 0; i < 9; i++)
            cmd_backlog.push_back(make_item(CMD_REFRESH, 127, 63, 127, 63, 1'b1, 0));
        cmd_backlog.push_back(make_item(CMD_FILL, 100, 15, 20, 24, 1'b0, 0));
        cmd_backlog.push_back(make_item(CMD_FILL, 127, 63, 127, 63, 1'b1, 0));
        for (int unsigned i = 0; i < 3; i++)
            cmd_backlog.push_back(make_item(CMD_REFRESH, 0, 0, 0, 0, 1'b0, 0));

        // random phases: mostly writes, mixed with refresh ticks and unused commands
        for (int unsigned phase = 0; phase < 4; phase++)
        begin
            for (int unsigned n = 0; n < 103; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 40)
                    cmd_backlog.push_back(make_item(CMD_PIXEL, $urandom_range(127),
                        $urandom_range(63), $urandom_range(127), $urandom_range(63),
                        $urandom_range(1), gap_by_phase[phase]));
                else if (roll < 62)
                begin
                    s_addr = $urandom_range(PANEL_BYTES - 1);
                    roll = $urandom_range(99);
                    if (roll < 70)
                    begin
                        e_addr = s_addr + $urandom_range(48);
                        if (e_addr >= PANEL_BYTES)
                            e_addr = PANEL_BYTES - 1;
                    end
                    else if (roll < 85)
                        e_addr = (s_addr > 0) ? $urandom_range(s_addr - 1) : 0;
                    else
                        e_addr = $urandom_range(PANEL_BYTES - 1);
                    cmd_backlog.push_back(make_item(CMD_FILL, s_addr % PANEL_COLS,
                        (s_addr / PANEL_COLS) * 8 + $urandom_range(7), e_addr % PANEL_COLS,
                        (e_addr / PANEL_COLS) * 8 + $urandom_range(7), $urandom_range(1),
                        gap_by_phase[phase]));
                end
                else if (roll < 95)
                    cmd_backlog.push_back(make_item(CMD_REFRESH, $urandom_range(127),
                        $urandom_range(63), $urandom_range(127), $urandom_range(63),
                        $urandom_range(1), gap_by_phase[phase]));
                else
                    cmd_backlog.push_back(make_item(CMD_UNUSED, $urandom_range(127),
                        $urandom_range(63), $urandom_range(127), $urandom_range(63),
                        $urandom_range(1), gap_by_phase[phase]));
            end
        end

        // reset
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain: every request taken, every page word seen, then a quiet tail
        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
        while (page_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && page_words_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
